FILE: src/scdr_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the sample clamp decimal reporter
// no dependencies

package scdr_pkg;

    // field widths
    localparam int SAMPLE_W = 10;
    localparam int THRESH_W = 14;
    localparam int CHAR_W   = 8;
    localparam int DIGIT_W  = 4;
    localparam int QUOT_W   = 10;
    localparam int NDIGITS  = 4;
    localparam int CNT_W    = 2;

    // configuration register indexes
    localparam logic [1:0] CFG_EIGHT_BIT = 2'd0;
    localparam logic [1:0] CFG_CLAMP     = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;

    // clamp mode codes
    localparam logic [1:0] CLAMP_FLOOR = 2'd1;
    localparam logic [1:0] CLAMP_CEIL  = 2'd2;

    localparam logic [THRESH_W-1:0] THRESH_MAX = 14'd9999;

    // characters
    localparam logic [CHAR_W-1:0] CHAR_CR   = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_LF   = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'd48;

    // divide by ten: x * 52429 >> 19 is exact for x below 262149
    localparam logic [15:0] RECIP_TEN = 16'd52429;
    localparam int          RECIP_SH  = 19;

    localparam logic [CNT_W-1:0] LAST_DIGIT = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_DIGIT,
        S_CR,
        S_LF
    } t_state;

endpackage

FILE: src/scdr_div10.sv
`timescale 1ns / 1ps
// shared divide-by-ten unit: quotient (low 10 bits) and remainder of a 14-bit value
// depends on scdr_pkg

module scdr_div10
    import scdr_pkg::*;
(
    input  logic [THRESH_W-1:0] i_x,
    output logic [QUOT_W-1:0]   o_quot,
    output logic [DIGIT_W-1:0]  o_rem
);

    logic [THRESH_W+15:0] w_prod;
    logic [THRESH_W-1:0]  w_quot_wide;
    logic [THRESH_W-1:0]  w_times_ten;
    logic [THRESH_W-1:0]  w_diff;

    assign w_prod      = THRESH_W'(0) + ({16'd0, i_x} * {{THRESH_W{1'b0}}, RECIP_TEN});
    assign w_quot_wide = THRESH_W'(w_prod >> RECIP_SH);
    // q * 10 as two shifted adds
    assign w_times_ten = (w_quot_wide << 3) + (w_quot_wide << 1);
    assign w_diff      = i_x - w_times_ten;

    assign o_quot = w_quot_wide[QUOT_W-1:0];
    assign o_rem  = w_diff[DIGIT_W-1:0];

endmodule

FILE: src/sample_clamp_decimal_reporter.sv
`timescale 1ns / 1ps
// the request is taken in idle, then the shared divide-by-ten unit forms the decimal
// digits (1 to 4) lowest first, then one character per cycle goes out while the
// receiver is ready: the digits most significant first, then CR and LF
// a new request is taken only after the LF of the previous line has been accepted
// synchronous active-low reset clears state and the configuration to zero

module sample_clamp_decimal_reporter
    import scdr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_addr,
    input  logic [THRESH_W-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [CHAR_W-1:0]   o_out_char,
    output logic                o_last
);

    t_state r_state, n_state;

    logic                r_eight_bit;
    logic [1:0]          r_clamp_mode;
    logic [THRESH_W-1:0] r_threshold;

    logic [THRESH_W-1:0] r_val;
    logic [CNT_W-1:0]    r_cnt;
    logic [DIGIT_W-1:0]  r_dig [NDIGITS];

    logic [THRESH_W-1:0] w_scaled;
    logic [THRESH_W-1:0] w_clamped;
    logic [QUOT_W-1:0]   w_quot;
    logic [DIGIT_W-1:0]  w_rem;
    logic                w_conv_done;

    scdr_div10 u_div10 (
        .i_x    (r_val),
        .o_quot (w_quot),
        .o_rem  (w_rem)
    );

    assign w_conv_done = (w_quot == QUOT_W'(0)) || (r_cnt == LAST_DIGIT);

    always_comb begin
        if (r_eight_bit) begin
            w_scaled = THRESH_W'(i_sample[SAMPLE_W-1:2]);
        end else begin
            w_scaled = THRESH_W'(i_sample);
        end
        case (r_clamp_mode)
            CLAMP_FLOOR: w_clamped = (w_scaled < r_threshold) ? r_threshold : w_scaled;
            CLAMP_CEIL:  w_clamped = (w_scaled > r_threshold) ? r_threshold : w_scaled;
            default:     w_clamped = w_scaled;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CONV;
            end
            S_CONV: begin
                if (w_conv_done) n_state = S_DIGIT;
            end
            S_DIGIT: begin
                if (i_out_ready && (r_cnt == CNT_W'(0))) n_state = S_CR;
            end
            S_CR: begin
                if (i_out_ready) n_state = S_LF;
            end
            S_LF: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_out_char  = CHAR_ZERO;
        o_last      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_DIGIT: begin
                o_out_valid = 1'b1;
                o_out_char  = CHAR_ZERO + CHAR_W'(r_dig[r_cnt]);
            end
            S_CR: begin
                o_out_valid = 1'b1;
                o_out_char  = CHAR_CR;
            end
            S_LF: begin
                o_out_valid = 1'b1;
                o_out_char  = CHAR_LF;
                o_last      = 1'b1;
            end
            default: begin
                o_in_ready  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_eight_bit  <= 1'b0;
            r_clamp_mode <= 2'd0;
            r_threshold  <= '0;
            r_cnt        <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_EIGHT_BIT: r_eight_bit  <= i_cfg_data[0];
                    CFG_CLAMP:     r_clamp_mode <= i_cfg_data[1:0];
                    // saturate once at write time
                    CFG_THRESHOLD: r_threshold  <= (i_cfg_data > THRESH_MAX) ?
                                                   THRESH_MAX : i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_cnt <= '0;
                end
                S_CONV: begin
                    if (!w_conv_done) r_cnt <= r_cnt + CNT_W'(1);
                end
                S_DIGIT: begin
                    if (i_out_ready && (r_cnt != CNT_W'(0))) r_cnt <= r_cnt - CNT_W'(1);
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_val <= w_clamped;
        end else if (r_state == S_CONV) begin
            r_val        <= THRESH_W'(w_quot);
            r_dig[r_cnt] <= w_rem;
        end
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// self-checking bench for sample_clamp_decimal_reporter: random-gap request driver,
// character monitor and a line predictor; depends on scdr_pkg and the block's rtl

module tb;
    import scdr_pkg::*;

    localparam int RAND_PHASES   = 11;
    localparam int PHASE_ITEMS   = 42;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PRINT_CAP     = 40;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_line_char;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_cfg_wr_en  = 1'b0;
    logic [1:0]          i_cfg_addr   = '0;
    logic [THRESH_W-1:0] i_cfg_data   = '0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_ready;
    logic [SAMPLE_W-1:0] i_sample     = '0;
    logic                o_out_valid;
    logic                i_out_ready  = 1'b0;
    logic [CHAR_W-1:0]   o_out_char;
    logic                o_last;

    // predictor copy of the register file
    logic                cfg_eight_bit = 1'b0;
    logic [1:0]          cfg_clamp     = '0;
    logic [THRESH_W-1:0] cfg_thresh    = '0;

    logic [SAMPLE_W-1:0] sample_q[$];
    t_line_char          line_q[$];

    bit idle_on = 1'b1;
    int in_gap  = 0;
    int out_gap = 0;

    int n_errors     = 0;
    int n_samples    = 0;
    int n_chars      = 0;
    int n_settings   = 0;

    sample_clamp_decimal_reporter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_char  (o_out_char),
        .o_last      (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report(input string msg);
        n_errors++;
        if (n_errors <= PRINT_CAP) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    // expected characters of one reported line: scale, clamp, then decimal without leading zeros, CR and LF
    function automatic void predict_line(input logic [SAMPLE_W-1:0] sample);
        logic [THRESH_W-1:0] lim;
        logic [THRESH_W-1:0] v;
        logic [DIGIT_W-1:0]  digits[NDIGITS];
        int                  n;
        lim = (cfg_thresh > THRESH_MAX) ? THRESH_MAX : cfg_thresh;
        v = cfg_eight_bit ? THRESH_W'(sample >> 2) : THRESH_W'(sample);
        if (cfg_clamp == CLAMP_FLOOR) begin
            if (v < lim) v = lim;
        end else if (cfg_clamp == CLAMP_CEIL) begin
            if (v > lim) v = lim;
        end
        n = 0;
        do begin
            digits[n] = DIGIT_W'(v % 10);
            v = THRESH_W'(v / 10);
            n++;
        end while (v != 0 && n < NDIGITS);
        for (int i = n - 1; i >= 0; i--) begin
            line_q.push_back('{ch: CHAR_ZERO + CHAR_W'(digits[i]), last: 1'b0});
        end
        line_q.push_back('{ch: CHAR_CR, last: 1'b0});
        line_q.push_back('{ch: CHAR_LF, last: 1'b1});
    endfunction

    // sample picker: edges, values around the threshold, and uniform noise
    function automatic logic [SAMPLE_W-1:0] pick_sample(input bit eb,
                                                        input logic [THRESH_W-1:0] th);
        int t;
        case ($urandom_range(0, 7))
            0: t = 0;
            1: t = 1023;
            2, 3: begin
                t = int'(th) + int'($urandom_range(0, 2)) - 1;
                if (eb) t = t * 4 + int'($urandom_range(0, 3));
            end
            default: t = int'($urandom_range(0, 1023));
        endcase
        if (t < 0 || t > 1023) t = int'($urandom_range(0, 1023));
        return SAMPLE_W'(t);
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [THRESH_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_EIGHT_BIT: cfg_eight_bit = val[0];
            CFG_CLAMP:     cfg_clamp     = val[1:0];
            CFG_THRESHOLD: cfg_thresh    = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(input bit eb, input logic [1:0] cm,
                            input logic [THRESH_W-1:0] th);
        write_reg(CFG_EIGHT_BIT, THRESH_W'(eb));
        write_reg(CFG_CLAMP, THRESH_W'(cm));
        write_reg(CFG_THRESHOLD, th);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // wait for every request to be taken and every character to come back
    task automatic drain();
        int waited;
        waited = 0;
        while ((sample_q.size() != 0 || i_in_valid || line_q.size() != 0)
               && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (sample_q.size() != 0 || i_in_valid) begin
            report($sformatf("%0d requests never taken", sample_q.size() + int'(i_in_valid)));
            sample_q.delete();
        end
        if (line_q.size() != 0) begin
            report($sformatf("%0d characters never arrived", line_q.size()));
            line_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (in_gap != 0) begin
                in_gap     <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                in_gap     <= $urandom_range(0, 5);
                i_in_valid <= 1'b0;
            end else if (sample_q.size() != 0) begin
                i_in_valid <= 1'b1;
                i_sample   <= sample_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_gap     <= 0;
        end else if (out_gap != 0) begin
            out_gap     <= out_gap - 1;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            out_gap     <= $urandom_range(0, 5);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // monitor: predict on accepted requests, check accepted characters
    always @(posedge i_clk) begin
        t_line_char want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_line(i_sample);
                n_samples++;
            end
            if (o_out_valid && i_out_ready) begin
                n_chars++;
                if (line_q.size() == 0) begin
                    report($sformatf("unexpected char 0x%02h last=%0b", o_out_char, o_last));
                end else begin
                    want = line_q.pop_front();
                    if (o_out_char !== want.ch) begin
                        report($sformatf("char 0x%02h, wanted 0x%02h", o_out_char, want.ch));
                    end
                    if (o_last !== want.last) begin
                        report($sformatf("last %0b, wanted %0b on char 0x%02h",
                                         o_last, want.last, want.ch));
                    end
                end
            end
        end
    end

    initial begin
        bit                  eb;
        logic [1:0]          cm;
        logic [THRESH_W-1:0] th;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers at reset: ten bits, pass through, digit-count boundaries
        sample_q = '{10'd0, 10'd1023, 10'd9, 10'd10, 10'd99, 10'd100, 10'd999,
                     10'd1000, 10'h155, 10'h2aa};
        drain();

        // eight-bit shift with the unused clamp code and an out-of-range threshold
        set_regs(1'b1, 2'd3, 14'h3fff);
        sample_q = '{10'd3, 10'd4, 10'd1023, 10'd40};
        drain();

        // floor and ceiling around the threshold, including sample equal to it
        set_regs(1'b0, CLAMP_FLOOR, 14'd500);
        sample_q = '{10'd499, 10'd500, 10'd501};
        drain();
        set_regs(1'b0, CLAMP_CEIL, 14'd500);
        sample_q = '{10'd499, 10'd500, 10'd1023};
        drain();

        // saturated threshold gives the four-digit line; a zero ceiling gives the line 0
        set_regs(1'b1, CLAMP_FLOOR, 14'h3fff);
        sample_q = '{10'd0};
        drain();
        set_regs(1'b0, CLAMP_FLOOR, 14'd10000);
        sample_q = '{10'd1023};
        drain();
        set_regs(1'b0, CLAMP_CEIL, 14'd0);
        sample_q = '{10'd1023};
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            eb = 1'($urandom_range(0, 1));
            cm = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 5))
                0: th = '0;
                1: th = THRESH_MAX;
                2: th = '1;
                3: th = THRESH_W'($urandom_range(0, 255));
                4: th = THRESH_W'($urandom_range(0, 1023));
                default: th = THRESH_W'($urandom_range(0, 16383));
            endcase
            set_regs(eb, cm, th);
            // last phase and a few others run with no gaps or stalls
            idle_on <= (p != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                sample_q.push_back(pick_sample(eb, th));
            end
            drain();
        end

        $display("covered %0d samples under %0d register settings, %0d characters checked",
                 n_samples, n_settings + 1, n_chars);
        if (n_errors == 0) begin
            $display("sample_clamp_decimal_reporter regression: pass");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("sample_clamp_decimal_reporter regression: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout with %0d characters outstanding", line_q.size());
        $display("sample_clamp_decimal_reporter regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
src/scdr_pkg.sv
src/scdr_div10.sv
src/sample_clamp_decimal_reporter.sv
bench/tb.sv
